// ----- sv/query_param_value_extract_core_defines.svh -----
// Assertion macros for the query parameter extractor.
`ifndef QUERY_PARAM_VALUE_EXTRACT_CORE_DEFINES_SVH
`define QUERY_PARAM_VALUE_EXTRACT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QPVE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define QPVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/qpve_pkg.sv -----
package qpve_pkg;

    localparam int MAX_VALUE_BYTES = 64;
    localparam int MAX_KEY_BYTES   = 8;
    localparam int VALUE_ADDR_W    = $clog2(MAX_VALUE_BYTES);
    localparam int COUNT_W         = $clog2(MAX_VALUE_BYTES + 1);
    localparam int KEY_CNT_W       = 4;
    localparam int KEY_IDX_W       = $clog2(MAX_KEY_BYTES);
    localparam int KEY_W           = 64;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 1'b1;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_QUEST   = 8'h3f;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_HIGH,
        ESC_LOW
    } esc_phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_SEND
    } emit_state_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count;
        logic               truncated;
    } run_info_t;

    // bit 4 set marks a non-hex character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = 5'(c - CH_LOWER_A + 8'd10);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = 5'(c - CH_UPPER_A + 8'd10);
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d = 5'(c - CH_DIGIT_0);
        end
        return d;
    endfunction

endpackage

// ----- sv/qpve_ram.sv -----
module qpve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/qpve_parse.sv -----
module qpve_parse
    import qpve_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    input  logic [KEY_W-1:0]        key_bytes,
    input  logic [KEY_CNT_W-1:0]    key_length,
    output logic                    wr_en,
    output logic [VALUE_ADDR_W-1:0] wr_addr,
    output logic [7:0]              wr_data,
    output logic                    end_valid,
    output run_info_t               run_info
);

    logic                 in_value_reg, in_value_next;
    esc_phase_t           esc_reg, esc_next;
    logic [4:0]           hi_reg, hi_next;
    logic [KEY_CNT_W-1:0] kcnt_reg, kcnt_next;
    logic                 mism_reg, mism_next;
    logic [COUNT_W-1:0]   vcount_reg, vcount_next;
    logic                 ovf_reg, ovf_next;
    logic                 match_reg, match_next;

    logic       take;
    logic [7:0] take_byte;
    logic [4:0] lo;
    logic [7:0] want;
    logic       key_len_bad;
    logic       found_end;

    assign key_len_bad = key_length > KEY_CNT_W'(MAX_KEY_BYTES);
    assign want        = key_bytes[8 * kcnt_reg[KEY_IDX_W-1:0] +: 8];
    assign lo          = hex_digit(in_byte);

    always_comb
    begin
        in_value_next = in_value_reg;
        esc_next      = esc_reg;
        hi_next       = hi_reg;
        kcnt_next     = kcnt_reg;
        mism_next     = mism_reg;
        vcount_next   = vcount_reg;
        ovf_next      = ovf_reg;
        match_next    = match_reg;
        wr_en         = 1'b0;
        wr_addr       = vcount_reg[VALUE_ADDR_W-1:0];
        take          = 1'b0;
        take_byte     = in_byte;

        if (accept && !match_reg)
        begin
            if (in_byte == CH_AMP && in_value_reg && !mism_reg)
            begin
                match_next    = 1'b1;
                in_value_next = 1'b0;
                esc_next      = ESC_NONE;
                hi_next       = '0;
            end else if (in_byte == CH_AMP || in_byte == CH_QUEST)
            begin
                in_value_next = 1'b0;
                esc_next      = ESC_NONE;
                hi_next       = '0;
                kcnt_next     = '0;
                mism_next     = 1'b0;
                vcount_next   = '0;
                ovf_next      = 1'b0;
            end else if (in_byte == CH_EQUAL && !in_value_reg)
            begin
                mism_next     = mism_reg || key_len_bad || (kcnt_reg != key_length);
                in_value_next = 1'b1;
                esc_next      = ESC_NONE;
                hi_next       = '0;
                vcount_next   = '0;
                ovf_next      = 1'b0;
            end else
            begin
                case (esc_reg)
                    ESC_NONE:
                    begin
                        if (in_byte == CH_PERCENT)
                        begin
                            esc_next = ESC_HIGH;
                        end else
                        begin
                            take = 1'b1;
                        end
                    end
                    ESC_HIGH:
                    begin
                        hi_next  = lo;
                        esc_next = ESC_LOW;
                    end
                    default:
                    begin
                        esc_next  = ESC_NONE;
                        hi_next   = '0;
                        take      = 1'b1;
                        take_byte = (!hi_reg[4] && !lo[4]) ? {hi_reg[3:0], lo[3:0]} : 8'h00;
                    end
                endcase

                if (take)
                begin
                    if (!in_value_reg)
                    begin
                        if (key_len_bad || kcnt_reg >= key_length)
                        begin
                            mism_next = 1'b1;
                        end else
                        begin
                            if (want != take_byte)
                            begin
                                mism_next = 1'b1;
                            end
                            kcnt_next = kcnt_reg + KEY_CNT_W'(1);
                        end
                    end else if (!mism_reg)
                    begin
                        if (vcount_reg < COUNT_W'(MAX_VALUE_BYTES))
                        begin
                            wr_en       = 1'b1;
                            vcount_next = vcount_reg + COUNT_W'(1);
                        end else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign wr_data = take_byte;

    // end of string closes the open pair
    assign found_end          = match_next || (in_value_next && !mism_next);
    assign end_valid          = accept && in_last;
    assign run_info.found     = found_end;
    assign run_info.count     = found_end ? vcount_next : '0;
    assign run_info.truncated = found_end && ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_value_reg <= 1'b0;
            esc_reg      <= ESC_NONE;
            hi_reg       <= '0;
            kcnt_reg     <= '0;
            mism_reg     <= 1'b0;
            vcount_reg   <= '0;
            ovf_reg      <= 1'b0;
            match_reg    <= 1'b0;
        end else if (end_valid)
        begin
            in_value_reg <= 1'b0;
            esc_reg      <= ESC_NONE;
            hi_reg       <= '0;
            kcnt_reg     <= '0;
            mism_reg     <= 1'b0;
            vcount_reg   <= '0;
            ovf_reg      <= 1'b0;
            match_reg    <= 1'b0;
        end else
        begin
            in_value_reg <= in_value_next;
            esc_reg      <= esc_next;
            hi_reg       <= hi_next;
            kcnt_reg     <= kcnt_next;
            mism_reg     <= mism_next;
            vcount_reg   <= vcount_next;
            ovf_reg      <= ovf_next;
            match_reg    <= match_next;
        end
    end

endmodule

// ----- sv/qpve_emit.sv -----
module qpve_emit
    import qpve_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    end_valid,
    input  run_info_t               run_info,
    output logic                    busy,
    output logic [VALUE_ADDR_W-1:0] rd_addr,
    input  logic [7:0]              rd_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    found,
    output logic                    byte_valid,
    output logic [7:0]              value_byte,
    output logic                    value_truncated,
    output logic                    run_end
);

    emit_state_t        state_reg, state_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               found_reg, found_next;
    logic               trunc_reg, trunc_next;
    logic               out_valid_reg;
    logic               found_out_reg;
    logic               byte_valid_out_reg;
    logic [7:0]         value_out_reg;
    logic               trunc_out_reg;
    logic               run_end_out_reg;

    logic single;
    logic last_idx;
    logic out_free;
    logic load;
    logic load_last;

    assign single   = !(found_reg && cnt_reg != '0);
    assign last_idx = (idx_reg + COUNT_W'(1)) == cnt_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            trunc_reg <= 1'b0;
        end else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            trunc_reg <= trunc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        trunc_next = trunc_reg;
        load       = 1'b0;
        load_last  = 1'b0;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (end_valid)
                begin
                    idx_next   = '0;
                    cnt_next   = run_info.count;
                    found_next = run_info.found;
                    trunc_next = run_info.truncated;
                    state_next = EM_READ;
                end
            end
            EM_READ:
            begin
                state_next = EM_SEND;
            end
            EM_SEND:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (single || last_idx)
                    begin
                        load_last  = 1'b1;
                        state_next = EM_IDLE;
                    end else
                    begin
                        idx_next = idx_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // address runs one ahead so the next byte is ready after each transfer
    assign rd_addr = idx_next[VALUE_ADDR_W-1:0];
    assign busy    = state_reg != EM_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (load)
        begin
            out_valid_reg <= 1'b1;
        end else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_out_reg      <= found_reg;
            byte_valid_out_reg <= !single;
            value_out_reg      <= single ? 8'h00 : rd_data;
            trunc_out_reg      <= !single && trunc_reg;
            run_end_out_reg    <= load_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign found           = found_out_reg;
    assign byte_valid      = byte_valid_out_reg;
    assign value_byte      = value_out_reg;
    assign value_truncated = trunc_out_reg;
    assign run_end         = run_end_out_reg;

endmodule

// ----- sv/query_param_value_extract_core.sv -----
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  in_byte, in_last
// out      output     out_valid/out_ready found, byte_valid, value_byte,
//                                        value_truncated, run_end
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle while parsing; the value buffer is a 64 x 8 RAM.
// After a last byte, input stalls (n results, n = 1..64)
// while the RAM is read out, one result per cycle unless out_ready is low.
// Reset clears all control state and the key registers; no clearing pass.
// cfg is always ready.
module query_param_value_extract_core
    import qpve_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic                   byte_valid,
    output logic [7:0]             value_byte,
    output logic                   value_truncated,
    output logic                   run_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [KEY_W-1:0]        key_bytes_reg;
    logic [KEY_CNT_W-1:0]    key_length_reg;
    logic                    accept;
    logic                    busy;
    logic                    wr_en;
    logic [VALUE_ADDR_W-1:0] wr_addr;
    logic [7:0]              wr_data;
    logic [VALUE_ADDR_W-1:0] rd_addr;
    logic [7:0]              rd_data;
    logic                    end_valid;
    run_info_t               run_info;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg  <= '0;
            key_length_reg <= '0;
        end else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_BYTES:  key_bytes_reg  <= cfg_data[KEY_W-1:0];
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    qpve_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .key_bytes  (key_bytes_reg),
        .key_length (key_length_reg),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .end_valid  (end_valid),
        .run_info   (run_info)
    );

    qpve_ram #(
        .WIDTH (8),
        .DEPTH (MAX_VALUE_BYTES)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    qpve_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .end_valid       (end_valid),
        .run_info        (run_info),
        .busy            (busy),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .byte_valid      (byte_valid),
        .value_byte      (value_byte),
        .value_truncated (value_truncated),
        .run_end         (run_end)
    );

endmodule

// ----- sv/qpve_checker.sv -----
`include "query_param_value_extract_core_defines.svh"

module qpve_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic       found,
    input logic       byte_valid,
    input logic [7:0] value_byte,
    input logic       value_truncated,
    input logic       run_end
);

    `QPVE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `QPVE_ASSERT_NEXT(a_last_stalls_in, in_valid && in_ready && in_last, !in_ready, "input taken during readout")
    `QPVE_ASSERT_NOW(a_empty_ends_run, out_valid && !byte_valid, run_end && value_byte == 8'h00 && !value_truncated, "empty result malformed")
    `QPVE_ASSERT_NOW(a_byte_needs_found, out_valid && byte_valid, found, "value byte without match")

endmodule

bind query_param_value_extract_core qpve_checker u_qpve_checker (.*);
